[rtl/rcpf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the RC pulse capture block with failsafe.
// Depends on nothing; every other file imports it.
package rcpf_pkg;

  // Fixed field widths of the item payloads.
  localparam int CHAN_FIELD_W = 2;
  localparam int STAMP_FIELD_W = 32;
  localparam int WIDTH_W = 12;
  localparam int DIV_W = 8;
  localparam int QUOT_W = 16;
  localparam int TMO_W = 4;
  localparam int OUT_CHANNELS = 3;

  // Configuration port layout.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  // Parameter defaults.
  localparam int NUM_CHANNELS_DEF = 3;
  localparam int STAMP_BITS_DEF = 32;

  // Register reset values.
  localparam logic [DIV_W-1:0] CYCLES_PER_US_RST = 8'd72;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 12'd800;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 12'd2200;
  localparam logic [TMO_W-1:0] TIMEOUT_LIMIT_RST = 4'd15;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLES_PER_US = 2'd0,
    CFG_MIN_WIDTH     = 2'd1,
    CFG_MAX_WIDTH     = 2'd2,
    CFG_TIMEOUT_LIMIT = 2'd3
  } cfg_reg_e_t;

  // Item command codes.
  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_SCAN,
    ST_TICK_APPLY,
    ST_EDGE_DIV,
    ST_EDGE_CHECK,
    ST_FINISH
  } state_t;

endpackage

[rtl/rcpf_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for edge and tick items, result items and
// configuration writes. Depends on rcpf_pkg for the field widths.

interface rcpf_in_if import rcpf_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [CHAN_FIELD_W-1:0]  channel;
  logic                     pin_level;
  logic [STAMP_FIELD_W-1:0] timestamp;

  modport source (output valid, command, channel, pin_level, timestamp, input ready);
  modport sink (input valid, command, channel, pin_level, timestamp, output ready);
endinterface

interface rcpf_out_if import rcpf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] width_ch0;
  logic [WIDTH_W-1:0] width_ch1;
  logic [WIDTH_W-1:0] width_ch2;
  logic               link_active;
  logic               pulse_accepted;

  modport source (output valid, width_ch0, width_ch1, width_ch2, link_active,
                  pulse_accepted, input ready);
  modport sink (input valid, width_ch0, width_ch1, width_ch2, link_active,
                pulse_accepted, output ready);
endinterface

interface rcpf_cfg_if import rcpf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/rc_pulse_capture_failsafe_top.sv]
`timescale 1ns / 1ps
// Top level of the RC pulse capture block with failsafe.
// Depends on rcpf_pkg, the channel interfaces in rcpf_if and rcpf_div.

// The block takes one item at a time. A rising edge goes from the idle
// state straight to the finish state; a falling edge first passes the
// pulse span through a serial divider one quotient bit per cycle, and a
// tick checks the timeout counters one per cycle against the limit and
// then applies the outcome to every channel. Every item gives one result
// item, held in an output register, so a new item may be taken while the
// previous result still waits. Configuration writes are always taken and
// should be made only while the block is idle.
module rc_pulse_capture_failsafe_top import rcpf_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rcpf_in_if.sink   in_ch,
  rcpf_out_if.source out_ch,
  rcpf_cfg_if.sink  cfg_ch
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CH_X = (CH_W > CHAN_FIELD_W) ? CH_W : CHAN_FIELD_W;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  // Configuration registers.
  logic [DIV_W-1:0]   cycles_per_us_r;
  logic [WIDTH_W-1:0] min_width_r;
  logic [WIDTH_W-1:0] max_width_r;
  logic [TMO_W-1:0]   timeout_limit_r;

  // Channel state.
  logic [STAMP_BITS-1:0] rise_r [NUM_CHANNELS];
  logic [WIDTH_W-1:0]    pw_r [NUM_CHANNELS];
  logic [TMO_W-1:0]      tmo_r [NUM_CHANNELS];
  logic                  active_r;

  // Sequencer and item registers.
  state_t                state_r, state_nxt;
  logic [CH_W-1:0]       ch_r;
  logic [CH_W-1:0]       scan_r;
  logic                  expired_r;
  logic                  acc_r;

  // Output register.
  logic                  out_valid_r;
  logic [WIDTH_W-1:0]    out_w0_r, out_w1_r, out_w2_r;
  logic                  out_link_r;
  logic                  out_acc_r;

  // Item decode and datapath signals.
  logic                  in_fire;
  logic                  out_load;
  logic [CH_X-1:0]       ch_ext;
  logic [CH_W-1:0]       in_ch_idx;
  logic                  ch_ok;
  logic [STAMP_BITS-1:0] stamp;
  logic [STAMP_BITS-1:0] span;
  logic                  div_start;
  logic                  div_done;
  logic [QUOT_W-1:0]     quotient;
  logic [DIV_W-1:0]      divisor;
  logic                  in_window;
  logic [WIDTH_W-1:0]    pw_pad [OUT_CHANNELS];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  // Channel index of the incoming edge item and its range check.
  assign ch_ext = CH_X'(in_ch.channel);
  assign in_ch_idx = ch_ext[CH_W-1:0];
  assign ch_ok = (int'(in_ch.channel) < NUM_CHANNELS);
  assign stamp = in_ch.timestamp[STAMP_BITS-1:0];
  assign span = stamp - rise_r[in_ch_idx];
  assign divisor = (cycles_per_us_r == '0) ? DIV_W'(1) : cycles_per_us_r;
  assign div_start = in_fire && (in_ch.command == CMD_EDGE) && ch_ok && !in_ch.pin_level;
  assign in_window = (quotient > QUOT_W'(min_width_r)) && (quotient < QUOT_W'(max_width_r));

  // Shared serial divider for the pulse span.
  rcpf_div #(
    .DIVIDEND_W(STAMP_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (span),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Widths shown on the result; channels beyond NUM_CHANNELS read zero.
  for (genvar g = 0; g < OUT_CHANNELS; g++) begin : g_pad
    if (g < NUM_CHANNELS) begin : g_live
      assign pw_pad[g] = pw_r[g];
    end else begin : g_none
      assign pw_pad[g] = '0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycles_per_us_r <= CYCLES_PER_US_RST;
      min_width_r <= MIN_WIDTH_RST;
      max_width_r <= MAX_WIDTH_RST;
      timeout_limit_r <= TIMEOUT_LIMIT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_e_t'(cfg_ch.index))
        CFG_CYCLES_PER_US: cycles_per_us_r <= cfg_ch.data[DIV_W-1:0];
        CFG_MIN_WIDTH:     min_width_r <= cfg_ch.data[WIDTH_W-1:0];
        CFG_MAX_WIDTH:     max_width_r <= cfg_ch.data[WIDTH_W-1:0];
        CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_ch.data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.command == CMD_TICK) begin
            state_nxt = ST_TICK_SCAN;
          end else if (div_start) begin
            state_nxt = ST_EDGE_DIV;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_TICK_SCAN: begin
        if (scan_r == LAST_CH) begin
          state_nxt = ST_TICK_APPLY;
        end
      end
      ST_TICK_APPLY: state_nxt = ST_FINISH;
      ST_EDGE_DIV: begin
        if (div_done) begin
          state_nxt = ST_EDGE_CHECK;
        end
      end
      ST_EDGE_CHECK: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Item bookkeeping: channel, scan position, expiry and acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 1'b0;
      expired_r <= 1'b0;
      scan_r <= '0;
      ch_r <= '0;
    end else begin
      if (in_fire) begin
        ch_r <= in_ch_idx;
        acc_r <= 1'b0;
        expired_r <= 1'b0;
        scan_r <= '0;
      end else if (state_r == ST_TICK_SCAN) begin
        // One timeout counter compared per cycle.
        if (tmo_r[scan_r] >= timeout_limit_r) begin
          expired_r <= 1'b1;
        end
        if (scan_r != LAST_CH) begin
          scan_r <= scan_r + 1'b1;
        end
      end else if (state_r == ST_EDGE_CHECK) begin
        acc_r <= in_window;
      end
    end
  end

  // Channel state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_r[i] <= '0;
        pw_r[i] <= '0;
        tmo_r[i] <= '0;
      end
    end else begin
      // Rising edge records the start of the pulse.
      if (in_fire && (in_ch.command == CMD_EDGE) && ch_ok && in_ch.pin_level) begin
        rise_r[in_ch_idx] <= stamp;
      end
      // Tick: count up while alive, otherwise drop the link and the widths.
      if (state_r == ST_TICK_APPLY) begin
        active_r <= !expired_r;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (expired_r) begin
            pw_r[i] <= '0;
          end else begin
            tmo_r[i] <= tmo_r[i] + 1'b1;
          end
        end
      end
      // Falling edge with an in-window width refreshes the channel.
      if ((state_r == ST_EDGE_CHECK) && in_window) begin
        pw_r[ch_r] <= quotient[WIDTH_W-1:0];
        tmo_r[ch_r] <= '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_w0_r <= pw_pad[0];
      out_w1_r <= pw_pad[1];
      out_w2_r <= pw_pad[2];
      out_link_r <= active_r;
      out_acc_r <= acc_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.width_ch0 = out_w0_r;
  assign out_ch.width_ch1 = out_w1_r;
  assign out_ch.width_ch2 = out_w2_r;
  assign out_ch.link_active = out_link_r;
  assign out_ch.pulse_accepted = out_acc_r;

endmodule

[rtl/rcpf_div.sv]
`timescale 1ns / 1ps
// Serial restoring divider: one quotient bit per cycle, keeps the low QUOT_W
// quotient bits. Depends on rcpf_pkg for the divisor and quotient widths.
module rcpf_div import rcpf_pkg::*; #(
  parameter int DIVIDEND_W = STAMP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIV_W-1:0]      divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] dvd_r;
  logic [DIV_W-1:0]      rem_r;
  logic [DIV_W-1:0]      div_r;
  logic [QUOT_W-1:0]     quo_r;
  logic [DIV_W:0]        trial;
  logic                  fits;
  logic [DIV_W-1:0]      rem_nxt;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, dvd_r[DIVIDEND_W-1]};
    fits = (trial >= {1'b0, div_r});
    if (fits) begin
      rem_nxt = DIV_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

[rtl/rcpf_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the RC pulse capture top level, bound to it.
// Depends on rcpf_pkg and on the top level's channel interfaces.
module rcpf_checker import rcpf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [WIDTH_W-1:0] w0,
  input logic [WIDTH_W-1:0] w1,
  input logic [WIDTH_W-1:0] w2,
  input logic               link,
  input logic               acc
);

  // A result item stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // A stalled result item keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({w0, w1, w2, link, acc}))
    else $error("stalled result item changed");

  // Taking an item leaves the sequencer busy, so the input is not ready right after it.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an item");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rc_pulse_capture_failsafe_top rcpf_checker u_rcpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .w0        (out_ch.width_ch0),
  .w1        (out_ch.width_ch1),
  .w2        (out_ch.width_ch2),
  .link      (out_ch.link_active),
  .acc       (out_ch.pulse_accepted)
);
